@@ design/gerode_pkg.sv @@
// Shared constants and helpers for the 3x3 grayscale erosion block.
package gerode_pkg;

   localparam int MAX_WIDTH_DEF = 1024;

   localparam int PIX_W      = 8;
   localparam int FW_W       = 11;
   localparam int FH_W       = 12;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 12;

   localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 12'd480;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

   function automatic logic [PIX_W-1:0] min3(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
      logic [PIX_W-1:0] m;
      m = (a < b) ? a : b;
      return (c < m) ? c : m;
   endfunction

endpackage

@@ design/grayscale_erosion_3x3.sv @@
// 3x3 grayscale erosion (minimum filter) over a raster pixel stream.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_pixel_value
//   rsp      out        rsp_valid / rsp_ready  rsp_eroded_value, rsp_frame_last
//   csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// One pixel per clock sustained while rsp takes results; the pixel that completes
// a window passes the line store read, then the min tree into the rsp register.
// Both line rows share one 16-bit wide memory, read at accept and written
// back as the pixel leaves the middle stage, so read and write never hit the
// same column.
// Reset clears counters, valid flags and column minima; line memory and data registers are not cleared.
// A stalled rsp holds the middle stage only when it carries a result.
module grayscale_erosion_3x3 #(
   parameter int MAX_WIDTH = gerode_pkg::MAX_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [gerode_pkg::PIX_W-1:0]        req_pixel_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [gerode_pkg::PIX_W-1:0]        rsp_eroded_value,
   output logic                                rsp_frame_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gerode_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gerode_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int AW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int PW = gerode_pkg::PIX_W;
   localparam int FH = gerode_pkg::FH_W;
   localparam int FW = gerode_pkg::FW_W;

   typedef struct packed {
      logic          emit;
      logic          last;
      logic [AW-1:0] col;
      logic [PW-1:0] pix;
   } s1_type;

   logic [FW-1:0]     frame_width_ff;
   logic [FH-1:0]     frame_height_ff;
   logic [AW-1:0]     w_last;
   logic [FH-1:0]     h_last;
   logic [AW-1:0]     col_ff, col_in;
   logic [FH-1:0]     row_ff, row_in;
   logic              req_fire, csr_fire, s1_go, out_free;
   logic              s1_vld_ff;
   s1_type            s1_ff, s1_in;
   logic [2*PW-1:0]   line_mem [MAX_WIDTH];
   logic [2*PW-1:0]   rd_ff;
   logic [PW-1:0]     cmin1_ff, cmin2_ff, cmin_new, win_min;
   logic              rsp_valid_ff;
   logic [PW-1:0]     rsp_value_ff;
   logic              rsp_last_ff;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid;
   assign req_fire  = req_valid && req_ready;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_go     = s1_vld_ff && (!s1_ff.emit || out_free);
   assign req_ready = !s1_vld_ff || s1_go;

   // Clamp the configured frame size to the supported range
   always_comb begin
      if (frame_width_ff < FW'(3)) begin
         w_last = AW'(2);
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         w_last = AW'(MAX_WIDTH - 1);
      end else begin
         w_last = AW'(frame_width_ff - FW'(1));
      end
      if (frame_height_ff < FH'(3)) begin
         h_last = FH'(2);
      end else begin
         h_last = frame_height_ff - FH'(1);
      end
   end

   // Position of the next pixel, wraps at end of row and end of frame
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (col_ff == w_last) begin
         col_in = '0;
         row_in = (row_ff == h_last) ? '0 : row_ff + FH'(1);
      end else begin
         col_in = col_ff + AW'(1);
      end
   end

   always_comb begin
      s1_in.emit = (row_ff >= FH'(2)) && (col_ff >= AW'(2));
      s1_in.last = (row_ff == h_last) && (col_ff == w_last);
      s1_in.col  = col_ff;
      s1_in.pix  = req_pixel_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= gerode_pkg::FRAME_WIDTH_RST;
         frame_height_ff <= gerode_pkg::FRAME_HEIGHT_RST;
         col_ff          <= '0;
         row_ff          <= '0;
      end else if (csr_fire) begin
         // Any known register write restarts the frame
         case (csr_index)
            gerode_pkg::REG_FRAME_WIDTH: begin
               frame_width_ff <= csr_data[FW-1:0];
               col_ff         <= '0;
               row_ff         <= '0;
            end
            gerode_pkg::REG_FRAME_HEIGHT: begin
               frame_height_ff <= csr_data[FH-1:0];
               col_ff          <= '0;
               row_ff          <= '0;
            end
            default: ;
         endcase
      end else if (req_fire) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Middle stage: line read data arrives, pixel waits with it
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_fire) begin
         s1_vld_ff <= 1'b1;
      end else if (s1_go) begin
         s1_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff <= s1_in;
      end
   end

   // Line memory: {upper, middle} per column; read at accept, write back
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_ff <= line_mem[col_ff];
      end
      if (s1_go) begin
         line_mem[s1_ff.col] <= {rd_ff[PW-1:0], s1_ff.pix};
      end
   end

   // Window kept as per-column minima; newest column comes from this stage
   assign cmin_new = gerode_pkg::min3(rd_ff[2*PW-1:PW], rd_ff[PW-1:0], s1_ff.pix);
   assign win_min  = gerode_pkg::min3(cmin1_ff, cmin2_ff, cmin_new);

   always_ff @(posedge clock) begin
      if (reset) begin
         cmin1_ff <= '0;
         cmin2_ff <= '0;
      end else if (s1_go) begin
         cmin1_ff <= cmin2_ff;
         cmin2_ff <= cmin_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go && s1_ff.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_ff.emit) begin
         rsp_value_ff <= win_min;
         rsp_last_ff  <= s1_ff.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_eroded_value = rsp_value_ff;
   assign rsp_frame_last   = rsp_last_ff;

`ifndef ASSERT_OFF
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      req_fire && s1_go |-> col_ff != s1_ff.col)
      else $error("line memory read and write hit the same column");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= w_last)
      else $error("column counter beyond row end");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= h_last)
      else $error("row counter beyond frame end");

   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && s1_ff.last |-> s1_ff.emit)
      else $error("frame end marked on a border pixel");

   a_result_not_lost: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !(s1_go && s1_ff.emit))
      else $error("result overwrites a pending transfer");
`endif

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the 3x3 grayscale erosion block: directed frames and random streams.
`timescale 1ns / 1ps

module tb_top;

   localparam int MIN_DIM                = 3;
   localparam int MAX_COLS               = gerode_pkg::MAX_WIDTH_DEF;
   localparam int RESET_CYCLES           = 7;
   localparam int SETTLE_CYCLES          = 8;
   localparam int TAIL_CYCLES            = 16;
   localparam int STALL_LIMIT            = 4000;
   localparam int MAX_REPORTS            = 50;
   localparam int RANDOM_ITEMS_PER_PHASE = 120;
   localparam logic [gerode_pkg::CSR_IDX_W-1:0] REG_UNMAPPED = 4'hF;

   typedef logic [gerode_pkg::PIX_W-1:0]      pixel_type;
   typedef logic [gerode_pkg::CSR_DATA_W-1:0] csr_data_type;

   typedef struct packed {
      logic [gerode_pkg::PIX_W-1:0] eroded;
      logic                         last;
   } erosion_result_type;

   typedef enum int {PIX_UNIFORM, PIX_BRIGHT, PIX_MOSTLY_WHITE} pixel_mix_type;

   logic                                clock           = 1'b0;
   logic                                reset           = 1'b1;
   logic                                req_valid       = 1'b0;
   logic                                req_ready;
   logic [gerode_pkg::PIX_W-1:0]        req_pixel_value = '0;
   logic                                rsp_valid;
   logic                                rsp_ready       = 1'b0;
   logic [gerode_pkg::PIX_W-1:0]        rsp_eroded_value;
   logic                                rsp_frame_last;
   logic                                csr_valid       = 1'b0;
   logic                                csr_ready;
   logic [gerode_pkg::CSR_IDX_W-1:0]    csr_index       = '0;
   logic [gerode_pkg::CSR_DATA_W-1:0]   csr_data        = '0;

   // predictor state
   logic [gerode_pkg::PIX_W-1:0] upper_line [MAX_COLS];
   logic [gerode_pkg::PIX_W-1:0] middle_line [MAX_COLS];
   logic [gerode_pkg::PIX_W-1:0] win_pix [9]          = '{default: '0};
   int unsigned                  col_pos              = 0;
   int unsigned                  row_pos              = 0;
   logic [gerode_pkg::FW_W-1:0]  cfg_width            = gerode_pkg::FRAME_WIDTH_RST;
   logic [gerode_pkg::FH_W-1:0]  cfg_height           = gerode_pkg::FRAME_HEIGHT_RST;

   erosion_result_type  expected_results [$];
   erosion_result_type  oldest_result;
   int                  mismatch_count       = 0;
   int                  results_seen         = 0;
   int unsigned         sender_idle_pct      = 0;
   int unsigned         receiver_stall_pct   = 0;
   int                  quiet_cycles         = 0;

   grayscale_erosion_3x3 u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_value  (req_pixel_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_eroded_value (rsp_eroded_value),
      .rsp_frame_last   (rsp_frame_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_REPORTS)
         $display("MISMATCH @%0t result %0d: %s", $realtime, results_seen, what);
      mismatch_count++;
   endtask

   // Advance the window by one pixel and queue the result it completes, if any.
   task automatic predict_erosion(input logic [gerode_pkg::PIX_W-1:0] pix);
      int unsigned                  w, h, c, r, i;
      logic [gerode_pkg::PIX_W-1:0] up, mid, low;
      erosion_result_type           res;
      w = (cfg_width < MIN_DIM) ? MIN_DIM : ((cfg_width > MAX_COLS) ? MAX_COLS : cfg_width);
      h = (cfg_height < MIN_DIM) ? MIN_DIM : cfg_height;
      if (col_pos >= w) col_pos = 0;
      if (row_pos >= h) row_pos = 0;
      c = col_pos;
      r = row_pos;
      up  = upper_line[c];
      mid = middle_line[c];
      upper_line[c]  = mid;
      middle_line[c] = pix;
      for (i = 0; i < 3; i++) begin
         win_pix[i*3]   = win_pix[i*3+1];
         win_pix[i*3+1] = win_pix[i*3+2];
      end
      win_pix[2] = up;
      win_pix[5] = mid;
      win_pix[8] = pix;
      if (r >= 2 && c >= 2) begin
         low = win_pix[0];
         for (i = 1; i < 9; i++)
            if (win_pix[i] < low) low = win_pix[i];
         res.eroded = low;
         res.last   = (r == h - 1) && (c == w - 1);
         expected_results.push_back(res);
      end
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endtask

   task automatic apply_register(input logic [gerode_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [gerode_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         gerode_pkg::REG_FRAME_WIDTH: begin
            cfg_width = data[gerode_pkg::FW_W-1:0];
            col_pos = 0;
            row_pos = 0;
         end
         gerode_pkg::REG_FRAME_HEIGHT: begin
            cfg_height = data[gerode_pkg::FH_W-1:0];
            col_pos = 0;
            row_pos = 0;
         end
         default: ;
      endcase
   endtask

   function automatic logic [gerode_pkg::PIX_W-1:0] random_pixel(input pixel_mix_type mix);
      case (mix)
         PIX_BRIGHT:
            return ($urandom_range(15) == 0) ? pixel_type'($urandom_range(255))
                                             : pixel_type'($urandom_range(255, 192));
         PIX_MOSTLY_WHITE:
            return ($urandom_range(7) == 0) ? pixel_type'($urandom_range(255)) : 8'hFF;
         default:
            return pixel_type'($urandom_range(255));
      endcase
   endfunction

   // Send one pixel; valid stays high after the transfer so back-to-back pixels need no drop.
   task automatic send_pixel(input logic [gerode_pkg::PIX_W-1:0] pix);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      predict_erosion(pix);
      req_valid       <= 1'b1;
      req_pixel_value <= pix;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_pixels(input int count, input pixel_mix_type mix);
      for (int i = 0; i < count; i++)
         send_pixel(random_pixel(mix));
   endtask

   // Hold the sender until every queued result is out, then let the pipeline settle.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [gerode_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [gerode_pkg::CSR_DATA_W-1:0] data);
      hold_until_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      apply_register(idx, data);
   endtask

   // Reset geometry is 640 wide; the first results come at columns 2 onward of row 2.
   task automatic test_reset_geometry();
      send_pixels(2 * int'(gerode_pkg::FRAME_WIDTH_RST) + 8, PIX_UNIFORM);
   endtask

   task automatic test_smallest_frame();
      logic [gerode_pkg::PIX_W-1:0] pattern [9];
      pattern = '{8'hAA, 8'h55, 8'hFE, 8'h7F, 8'h80, 8'hF0, 8'h0F, 8'hC3, 8'h3C};
      write_register(gerode_pkg::REG_FRAME_WIDTH, 12'd3);
      write_register(gerode_pkg::REG_FRAME_HEIGHT, 12'd3);
      for (int i = 0; i < 9; i++) send_pixel(8'hFF);
      // widths and heights below 3 clamp up to 3
      write_register(gerode_pkg::REG_FRAME_WIDTH, 12'd0);
      write_register(gerode_pkg::REG_FRAME_HEIGHT, 12'd2);
      for (int i = 0; i < 9; i++) send_pixel((i == 0) ? 8'h00 : 8'hFF);
      // next frame follows the wrap without a write
      for (int i = 0; i < 9; i++) send_pixel(pattern[i]);
   endtask

   task automatic test_restart_mid_frame();
      write_register(gerode_pkg::REG_FRAME_WIDTH, 12'd6);
      write_register(gerode_pkg::REG_FRAME_HEIGHT, 12'd5);
      send_pixels(14, PIX_UNIFORM);
      write_register(gerode_pkg::REG_FRAME_WIDTH, 12'd6);
      send_pixels(30, PIX_UNIFORM);
   endtask

   task automatic test_unmapped_register();
      write_register(gerode_pkg::REG_FRAME_WIDTH, 12'd4);
      write_register(gerode_pkg::REG_FRAME_HEIGHT, 12'd4);
      send_pixels(7, PIX_UNIFORM);
      // an unmapped index leaves the frame position alone
      write_register(REG_UNMAPPED, 12'hFFF);
      send_pixels(9, PIX_UNIFORM);
   endtask

   task automatic configure_random_geometry();
      logic [gerode_pkg::CSR_DATA_W-1:0] width_data, height_data;
      int unsigned                       pick;
      case ($urandom_range(9))
         0:       width_data = csr_data_type'($urandom_range(2));
         1:       width_data = csr_data_type'(12'h800 | $urandom_range(24, 3));
         2:       width_data = csr_data_type'($urandom);
         default: width_data = csr_data_type'($urandom_range(24, 3));
      endcase
      case ($urandom_range(9))
         0:       height_data = csr_data_type'($urandom_range(2));
         1:       height_data = csr_data_type'($urandom);
         default: height_data = csr_data_type'($urandom_range(10, 3));
      endcase
      pick = $urandom_range(3);
      if (pick != 1) write_register(gerode_pkg::REG_FRAME_WIDTH, width_data);
      if (pick != 0) write_register(gerode_pkg::REG_FRAME_HEIGHT, height_data);
   endtask

   task automatic test_random_traffic();
      int unsigned    idle_by_phase [4];
      int unsigned    stall_by_phase [4];
      int             sent, chunk, pause_at;
      pixel_mix_type  mix;
      idle_by_phase  = '{0, 75, 0, 10};
      stall_by_phase = '{0, 0, 75, 10};
      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct    = idle_by_phase[phase];
         receiver_stall_pct = stall_by_phase[phase];
         sent     = 0;
         pause_at = $urandom_range(RANDOM_ITEMS_PER_PHASE - 1, 10);
         while (sent < RANDOM_ITEMS_PER_PHASE) begin
            configure_random_geometry();
            chunk = $urandom_range(60, 20);
            if (chunk > RANDOM_ITEMS_PER_PHASE - sent) chunk = RANDOM_ITEMS_PER_PHASE - sent;
            mix   = pixel_mix_type'($urandom_range(2));
            for (int i = 0; i < chunk; i++) begin
               if (sent == pause_at) hold_until_drained();
               send_pixel(random_pixel(mix));
               sent++;
            end
         end
      end
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
   endtask

   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result eroded=%0d last=%0b",
                                      rsp_eroded_value, rsp_frame_last));
         end else begin
            oldest_result = expected_results.pop_front();
            if (rsp_eroded_value !== oldest_result.eroded)
               report_mismatch($sformatf("eroded_value got %0d want %0d",
                                         rsp_eroded_value, oldest_result.eroded));
            if (rsp_frame_last !== oldest_result.last)
               report_mismatch($sformatf("frame_last got %0b want %0b",
                                         rsp_frame_last, oldest_result.last));
         end
         results_seen++;
      end
   end

   // Count cycles without any transfer on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d results pending",
                  quiet_cycles, expected_results.size());
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_reset_geometry();
      test_smallest_frame();
      test_restart_mid_frame();
      test_unmapped_register();
      test_random_traffic();
      hold_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/gerode_pkg.sv
design/grayscale_erosion_3x3.sv
verif/tb_top.sv
